/* design/nmha_pkg.sv */
package nmha_pkg;

    // Store geometry.
    localparam int MAX_MEDOIDS = 16;
    localparam int MAX_WORDS   = 16;
    localparam int MED_W       = $clog2(MAX_MEDOIDS);
    localparam int WRD_W       = $clog2(MAX_WORDS);
    localparam int MEM_DEPTH   = MAX_MEDOIDS * MAX_WORDS;
    localparam int MEM_AW      = MED_W + WRD_W;

    // Field widths.
    localparam int WORD_W   = 64;
    localparam int SLOT_W   = 4;
    localparam int INDEX_W  = 4;
    localparam int KCFG_W   = 5;
    localparam int SITES_W  = 11;
    localparam int DIST_W   = 11;
    localparam int CFG_W    = 11;
    localparam int POP_W    = 7;
    localparam int SITE_CAP = 64 * MAX_WORDS;
    localparam int DIST_MAX = 2047;

    // Request codes.
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // Configuration register indexes.
    localparam logic CFG_NUM_MEDOIDS = 1'b0;
    localparam logic CFG_NUM_SITES   = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_MIN,
        S_OUT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic             accept;
        logic             scan_rd;
        logic             min_step;
        logic             out_load;
        logic [MED_W-1:0] cnt;
    } ctl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic             q_go;
        logic             last_word;
        logic [MED_W-1:0] k_last;
        logic             out_free;
    } dp_status_t;

endpackage

/* design/nmha_dp.sv */
module nmha_dp (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic                           cfg_index,
    input  logic [nmha_pkg::CFG_W-1:0]     cfg_data,
    input  logic                           req_type,
    input  logic [nmha_pkg::SLOT_W-1:0]    medoid_slot,
    input  logic [nmha_pkg::INDEX_W-1:0]   word_index,
    input  logic [nmha_pkg::WORD_W-1:0]    word_data,
    input  logic                           out_stall,
    output logic                           out_valid,
    output logic [nmha_pkg::MED_W-1:0]     best_medoid,
    output logic [nmha_pkg::DIST_W-1:0]    distance,
    input  nmha_pkg::ctl_cmd_t             cmd,
    output nmha_pkg::dp_status_t           status
);

    logic [nmha_pkg::KCFG_W-1:0]  num_medoids_reg;
    logic [nmha_pkg::SITES_W-1:0] num_sites_reg;
    logic [nmha_pkg::KCFG_W-1:0]  eff_k;
    logic [nmha_pkg::SITES_W-1:0] eff_sites;
    logic [nmha_pkg::SITES_W+1:0] sites_up;
    logic [6:0]                   num_words;
    logic                         in_range;
    logic                         is_last;
    logic [nmha_pkg::SITES_W-1:0] rem;
    logic [nmha_pkg::WORD_W-1:0]  mask;
    logic                         q_go;
    logic                         mem_we;
    logic [nmha_pkg::MEM_AW-1:0]  wr_addr;
    logic [nmha_pkg::MEM_AW-1:0]  rd_addr;

    logic [nmha_pkg::WORD_W-1:0]  mem [nmha_pkg::MEM_DEPTH];
    logic [nmha_pkg::WORD_W-1:0]  rd_data_reg;
    logic                         rd_vld_reg;
    logic [nmha_pkg::MED_W-1:0]   rd_idx_reg;

    logic [nmha_pkg::WORD_W-1:0]  q_data_reg;
    logic [nmha_pkg::WORD_W-1:0]  q_mask_reg;
    logic [nmha_pkg::WRD_W-1:0]   q_widx_reg;
    logic                         q_last_reg;

    logic [nmha_pkg::DIST_W-1:0]  sums_reg [nmha_pkg::MAX_MEDOIDS];
    logic [nmha_pkg::POP_W-1:0]   pop;
    logic [nmha_pkg::DIST_W:0]    acc;
    logic [nmha_pkg::DIST_W-1:0]  acc_sat;

    logic [nmha_pkg::MED_W-1:0]   best_idx_reg;
    logic [nmha_pkg::DIST_W-1:0]  best_dist_reg;
    logic                         out_valid_reg;
    logic [nmha_pkg::MED_W-1:0]   best_medoid_reg;
    logic [nmha_pkg::DIST_W-1:0]  distance_reg;
    logic                         out_free;

    // Population count of one word as a pairwise adder tree, six levels deep.
    function automatic logic [nmha_pkg::POP_W-1:0] popcount(
        input logic [nmha_pkg::WORD_W-1:0] x
    );
        logic [nmha_pkg::POP_W-1:0] lvl [nmha_pkg::WORD_W];
        for (int b = 0; b < nmha_pkg::WORD_W; b++)
        begin
            lvl[b] = nmha_pkg::POP_W'(x[b]);
        end
        for (int w = nmha_pkg::WORD_W / 2; w >= 1; w = w / 2)
        begin
            for (int i = 0; i < w; i++)
            begin
                lvl[i] = lvl[2 * i] + lvl[2 * i + 1];
            end
        end
        return lvl[0];
    endfunction

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_medoids_reg <= nmha_pkg::KCFG_W'(1);
            num_sites_reg   <= nmha_pkg::SITES_W'(64);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                nmha_pkg::CFG_NUM_MEDOIDS: num_medoids_reg <= cfg_data[nmha_pkg::KCFG_W-1:0];
                nmha_pkg::CFG_NUM_SITES:   num_sites_reg   <= cfg_data;
                default:                   ;
            endcase
        end
    end

    // Clamp the settings into their working range.
    always_comb
    begin
        if (num_medoids_reg == '0)
            eff_k = nmha_pkg::KCFG_W'(1);
        else if (32'(num_medoids_reg) > nmha_pkg::MAX_MEDOIDS)
            eff_k = nmha_pkg::KCFG_W'(nmha_pkg::MAX_MEDOIDS);
        else
            eff_k = num_medoids_reg;

        if (num_sites_reg == '0)
            eff_sites = nmha_pkg::SITES_W'(1);
        else if (32'(num_sites_reg) > nmha_pkg::SITE_CAP)
            eff_sites = nmha_pkg::SITES_W'(nmha_pkg::SITE_CAP);
        else
            eff_sites = num_sites_reg;
    end

    // Word count, range check and the site mask of the incoming word.
    always_comb
    begin
        sites_up  = (nmha_pkg::SITES_W+2)'(eff_sites) + (nmha_pkg::SITES_W+2)'(63);
        num_words = sites_up[nmha_pkg::SITES_W+1:6];
        in_range  = 7'(word_index) < num_words;
        is_last   = 7'(word_index) == (num_words - 7'd1);
        rem       = eff_sites - nmha_pkg::SITES_W'({word_index, 6'b0});
        if (rem >= nmha_pkg::SITES_W'(64))
            mask = '1;
        else
            mask = (nmha_pkg::WORD_W'(1) << rem[5:0]) - nmha_pkg::WORD_W'(1);
        q_go = (req_type == nmha_pkg::REQ_QUERY) && in_range;
    end

    // Medoid store: written by load words, read once per medoid during a scan.
    assign mem_we  = cmd.accept && (req_type == nmha_pkg::REQ_LOAD)
                   && (32'(medoid_slot) < nmha_pkg::MAX_MEDOIDS)
                   && (32'(word_index) < nmha_pkg::MAX_WORDS);
    assign wr_addr = {medoid_slot[nmha_pkg::MED_W-1:0], word_index[nmha_pkg::WRD_W-1:0]};
    assign rd_addr = {cmd.cnt, q_widx_reg};

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[wr_addr] <= word_data;
        rd_data_reg <= mem[rd_addr];
    end

    // Read pipeline tags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= cmd.scan_rd;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg <= cmd.cnt;
        if (cmd.accept && q_go)
        begin
            q_data_reg <= word_data;
            q_mask_reg <= mask;
            q_widx_reg <= word_index[nmha_pkg::WRD_W-1:0];
            q_last_reg <= is_last;
        end
    end

    // Distance accumulation with saturation.
    always_comb
    begin
        pop     = popcount((q_data_reg ^ rd_data_reg) & q_mask_reg);
        acc     = (nmha_pkg::DIST_W+1)'(sums_reg[rd_idx_reg])
                + (nmha_pkg::DIST_W+1)'(pop);
        acc_sat = acc[nmha_pkg::DIST_W] ? nmha_pkg::DIST_W'(nmha_pkg::DIST_MAX)
                                        : acc[nmha_pkg::DIST_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int m = 0; m < nmha_pkg::MAX_MEDOIDS; m++)
            begin
                sums_reg[m] <= '0;
            end
        end
        else if (cmd.accept && q_go && (word_index == '0))
        begin
            for (int m = 0; m < nmha_pkg::MAX_MEDOIDS; m++)
            begin
                sums_reg[m] <= '0;
            end
        end
        else if (rd_vld_reg)
        begin
            sums_reg[rd_idx_reg] <= acc_sat;
        end
    end

    // Running minimum over the medoids in use; ties keep the lower number.
    always_ff @(posedge clk)
    begin
        if (cmd.min_step)
        begin
            if (cmd.cnt == '0)
            begin
                best_idx_reg  <= '0;
                best_dist_reg <= sums_reg[0];
            end
            else if (sums_reg[cmd.cnt] < best_dist_reg)
            begin
                best_idx_reg  <= cmd.cnt;
                best_dist_reg <= sums_reg[cmd.cnt];
            end
        end
    end

    // Output register, free when empty or being taken.
    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            best_medoid_reg <= best_idx_reg;
            distance_reg    <= best_dist_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign best_medoid = best_medoid_reg;
    assign distance    = distance_reg;

    always_comb
    begin
        status.q_go      = q_go;
        status.last_word = q_last_reg;
        status.k_last    = nmha_pkg::MED_W'(eff_k - nmha_pkg::KCFG_W'(1));
        status.out_free  = out_free;
    end

    // A new word must never overwrite a result that is still stalled.
    a_out_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || !out_stall))
        else $error("result word loaded over a stalled result");

    // The minimum search only visits medoids in use.
    a_min_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.min_step |-> (cmd.cnt <= status.k_last))
        else $error("minimum search beyond the medoids in use");

    // Accumulation never runs while the store is being loaded.
    a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        rd_vld_reg |-> !mem_we)
        else $error("medoid store written during a scan");

endmodule

/* design/nmha_ctrl.sv */
module nmha_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  nmha_pkg::dp_status_t  status,
    output nmha_pkg::ctl_cmd_t    cmd
);

    nmha_pkg::state_t             state_reg;
    nmha_pkg::state_t             state_next;
    logic [nmha_pkg::MED_W-1:0]   cnt_reg;
    logic [nmha_pkg::MED_W-1:0]   cnt_next;
    logic                         accept;

    assign in_stall = (state_reg != nmha_pkg::S_IDLE);
    assign accept   = in_valid && !in_stall;

    // State and counter registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= nmha_pkg::S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        cmd.accept   = accept;
        cmd.scan_rd  = 1'b0;
        cmd.min_step = 1'b0;
        cmd.out_load = 1'b0;
        cmd.cnt      = cnt_reg;

        unique case (state_reg)
            nmha_pkg::S_IDLE:
            begin
                if (accept && status.q_go)
                begin
                    state_next = nmha_pkg::S_SCAN;
                    cnt_next   = '0;
                end
            end
            nmha_pkg::S_SCAN:
            begin
                cmd.scan_rd = 1'b1;
                cnt_next    = cnt_reg + nmha_pkg::MED_W'(1);
                if (32'(cnt_reg) == nmha_pkg::MAX_MEDOIDS - 1)
                    state_next = nmha_pkg::S_DRAIN;
            end
            nmha_pkg::S_DRAIN:
            begin
                cnt_next   = '0;
                state_next = status.last_word ? nmha_pkg::S_MIN : nmha_pkg::S_IDLE;
            end
            nmha_pkg::S_MIN:
            begin
                cmd.min_step = 1'b1;
                if (cnt_reg == status.k_last)
                    state_next = nmha_pkg::S_OUT;
                else
                    cnt_next = cnt_reg + nmha_pkg::MED_W'(1);
            end
            nmha_pkg::S_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = nmha_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = nmha_pkg::S_IDLE;
            end
        endcase
    end

    // An in-range query word always starts a scan.
    a_query_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && status.q_go) |=> (state_reg == nmha_pkg::S_SCAN))
        else $error("accepted query word did not start a scan");

    // The drain cycle follows the last read of a scan.
    a_drain_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == nmha_pkg::S_DRAIN) |-> ($past(state_reg) == nmha_pkg::S_SCAN))
        else $error("drain entered without a scan");

    // The minimum search starts from the first medoid.
    a_min_starts_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == nmha_pkg::S_MIN && $past(state_reg) == nmha_pkg::S_DRAIN)
        |-> (cnt_reg == '0))
        else $error("minimum search did not start at medoid zero");

endmodule

/* design/nearest_medoid_hamming_assign.sv */
// Assigns a binary haplotype, sent as 64-bit words, to the nearest of up to 16
// stored medoids by Hamming distance. A load word (req_type 0) writes one word of
// one medoid into the store. A query word (req_type 1) with word_index 0 starts a
// new haplotype; each query word inside the configured site count is accepted,
// read against the medoid store once per medoid and then drained, and no new word
// is taken until it is through; a query word beyond the site count is dropped. The
// last word of a haplotype adds a minimum search over the medoids in use (the
// medoid count after clamping) and the load of the result, which waits while an
// earlier result is still stalled in the output register; the new result then
// waits there while the next words are taken. Ties go to the lower medoid number.
// Configuration writes must be made while the block is idle.
module nearest_medoid_hamming_assign (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [nmha_pkg::CFG_W-1:0]    cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          req_type,
    input  logic [nmha_pkg::SLOT_W-1:0]   medoid_slot,
    input  logic [nmha_pkg::INDEX_W-1:0]  word_index,
    input  logic [nmha_pkg::WORD_W-1:0]   word_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [nmha_pkg::MED_W-1:0]    best_medoid,
    output logic [nmha_pkg::DIST_W-1:0]   distance
);

    nmha_pkg::ctl_cmd_t   cmd;
    nmha_pkg::dp_status_t status;

    // Sequencer.
    nmha_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // Store, accumulators and output register.
    nmha_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .req_type    (req_type),
        .medoid_slot (medoid_slot),
        .word_index  (word_index),
        .word_data   (word_data),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .best_medoid (best_medoid),
        .distance    (distance),
        .cmd         (cmd),
        .status      (status)
    );

endmodule

/* bench/testbench.sv */
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE_CYCLES = 40;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int PRINT_LIMIT   = 50;

    // One nearest-medoid answer: medoid number and Hamming distance.
    typedef struct packed {
        logic [nmha_pkg::MED_W-1:0]  medoid;
        logic [nmha_pkg::DIST_W-1:0] ham;
    } nearest_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          cfg_we = 1'b0;
    logic                          cfg_index = nmha_pkg::CFG_NUM_MEDOIDS;
    logic [nmha_pkg::CFG_W-1:0]    cfg_data = '0;
    logic                          in_valid = 1'b0;
    logic                          in_stall;
    logic                          req_type = nmha_pkg::REQ_LOAD;
    logic [nmha_pkg::SLOT_W-1:0]   medoid_slot = '0;
    logic [nmha_pkg::INDEX_W-1:0]  word_index = '0;
    logic [nmha_pkg::WORD_W-1:0]   word_data = '0;
    logic                          out_valid;
    logic                          out_stall = 1'b0;
    logic [nmha_pkg::MED_W-1:0]    best_medoid;
    logic [nmha_pkg::DIST_W-1:0]   distance;

    // Our own copy of the block's state and configuration.
    logic [nmha_pkg::WORD_W-1:0]   medoid_copy [nmha_pkg::MAX_MEDOIDS][nmha_pkg::MAX_WORDS];
    logic [nmha_pkg::DIST_W-1:0]   running_ham [nmha_pkg::MAX_MEDOIDS];
    logic [nmha_pkg::KCFG_W-1:0]   medoid_cfg = 5'd1;
    logic [nmha_pkg::SITES_W-1:0]  sites_cfg = 11'd64;

    nearest_t pending_nearest [$];
    int       mismatches = 0;
    int       items_sent = 0;
    int       burst_left = 1;
    bit       valid_held = 1'b0;
    int       cycle_count = 0;
    int       stall_mode = 0;
    int       stall_left = 0;

    nearest_medoid_hamming_assign dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .req_type    (req_type),
        .medoid_slot (medoid_slot),
        .word_index  (word_index),
        .word_data   (word_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .best_medoid (best_medoid),
        .distance    (distance)
    );

    always #1 clk = ~clk;

    function automatic logic [nmha_pkg::WORD_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Site and word counts after the out-of-range clamping.
    function automatic int eff_site_count();
        if (sites_cfg == 0)
        begin
            return 1;
        end
        if (sites_cfg > nmha_pkg::SITE_CAP)
        begin
            return nmha_pkg::SITE_CAP;
        end
        return int'(sites_cfg);
    endfunction

    function automatic int eff_word_count();
        return (eff_site_count() + 63) / 64;
    endfunction

    // Updates the state for one accepted word and queues the answer it causes.
    function automatic void predict_nearest(logic rq, logic [nmha_pkg::SLOT_W-1:0] slot,
                                            logic [nmha_pkg::INDEX_W-1:0] idx,
                                            logic [nmha_pkg::WORD_W-1:0] data);
        int sites;
        int words;
        int rem;
        int k;
        int best;
        int sum;
        logic [nmha_pkg::WORD_W-1:0] mask;
        logic [nmha_pkg::DIST_W-1:0] best_ham;
        nearest_t answer;
        if (rq == nmha_pkg::REQ_LOAD)
        begin
            medoid_copy[slot][idx] = data;
            return;
        end
        sites = eff_site_count();
        words = eff_word_count();
        if (idx >= words)
        begin
            return;
        end
        rem = sites - idx * 64;
        mask = (rem >= 64) ? {nmha_pkg::WORD_W{1'b1}} : ((64'd1 << rem) - 64'd1);
        if (idx == 0)
        begin
            for (int m = 0; m < nmha_pkg::MAX_MEDOIDS; m++)
            begin
                running_ham[m] = '0;
            end
        end
        // Every medoid accumulates, whatever the medoid count.
        for (int m = 0; m < nmha_pkg::MAX_MEDOIDS; m++)
        begin
            sum = running_ham[m] + $countones((data ^ medoid_copy[m][idx]) & mask);
            running_ham[m] = (sum > nmha_pkg::DIST_MAX) ?
                             nmha_pkg::DIST_W'(nmha_pkg::DIST_MAX) : sum[nmha_pkg::DIST_W-1:0];
        end
        if (idx != words - 1)
        begin
            return;
        end
        k = (medoid_cfg == 0) ? 1 :
            ((medoid_cfg > nmha_pkg::MAX_MEDOIDS) ? nmha_pkg::MAX_MEDOIDS : int'(medoid_cfg));
        best = 0;
        best_ham = running_ham[0];
        for (int m = 1; m < k; m++)
        begin
            if (running_ham[m] < best_ham)
            begin
                best_ham = running_ham[m];
                best = m;
            end
        end
        answer.medoid = best[nmha_pkg::MED_W-1:0];
        answer.ham = best_ham;
        pending_nearest = {pending_nearest, answer};
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatches < PRINT_LIMIT)
        begin
            $display("mismatch at %0t ns: %s, got %0d, want %0d", $realtime, what, got, want);
        end
        mismatches++;
    endtask

    // Sends one word and waits for it to be taken; bursts end in a random gap.
    task automatic send_word(input logic rq, input int slot, input int idx,
                             input logic [nmha_pkg::WORD_W-1:0] data);
        in_valid <= 1'b1;
        valid_held = 1'b1;
        req_type <= rq;
        medoid_slot <= nmha_pkg::SLOT_W'(slot);
        word_index <= nmha_pkg::INDEX_W'(idx);
        word_data <= data;
        do @(posedge clk); while (in_stall);
        predict_nearest(rq, nmha_pkg::SLOT_W'(slot), nmha_pkg::INDEX_W'(idx), data);
        items_sent++;
        burst_left--;
        if (burst_left <= 0)
        begin
            in_valid <= 1'b0;
            valid_held = 1'b0;
            repeat ($urandom_range(1, ($urandom_range(3) == 0) ? 24 : 6)) @(posedge clk);
            burst_left = ($urandom_range(4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
        end
    endtask

    task automatic send_query(input int idx, input logic [nmha_pkg::WORD_W-1:0] data);
        send_word(nmha_pkg::REQ_QUERY, $urandom_range(nmha_pkg::MAX_MEDOIDS - 1), idx, data);
    endtask

    // Holds the sender back until every answer has come, then lets the block settle.
    task automatic drain_results(input int settle);
        if (valid_held)
        begin
            in_valid <= 1'b0;
            valid_held = 1'b0;
        end
        while (pending_nearest.size() != 0) @(posedge clk);
        repeat (settle + 1) @(posedge clk);
    endtask

    // Writes both registers; only called once the block is idle.
    task automatic configure(input int k, input int sites);
        drain_results(SETTLE_CYCLES);
        cfg_we <= 1'b1;
        cfg_index <= nmha_pkg::CFG_NUM_MEDOIDS;
        cfg_data <= nmha_pkg::CFG_W'(nmha_pkg::KCFG_W'(k));
        @(posedge clk);
        medoid_cfg = nmha_pkg::KCFG_W'(k);
        cfg_index <= nmha_pkg::CFG_NUM_SITES;
        cfg_data <= nmha_pkg::CFG_W'(sites);
        @(posedge clk);
        sites_cfg = nmha_pkg::SITES_W'(sites);
        cfg_we <= 1'b0;
    endtask

    // A query word close to a given medoid word, an exact copy, or unrelated.
    function automatic logic [nmha_pkg::WORD_W-1:0] near_word(int slot, int idx);
        logic [nmha_pkg::WORD_W-1:0] noise;
        noise = rand64() & rand64() & rand64();
        case ($urandom_range(3))
            0: return medoid_copy[slot][idx];
            1: return rand64();
            default: return medoid_copy[slot][idx] ^ noise;
        endcase
    endfunction

    task automatic send_haplotype(input int slot, input int words);
        for (int i = 0; i < words; i++)
        begin
            send_query(i, near_word(slot, i));
        end
    endtask

    // Writes every medoid word so that no query reads an unwritten entry.
    task automatic test_store_fill();
        for (int s = 0; s < nmha_pkg::MAX_MEDOIDS; s++)
        begin
            for (int w = 0; w < nmha_pkg::MAX_WORDS; w++)
            begin
                if (s == 0 && w == 0)
                begin
                    send_word(nmha_pkg::REQ_LOAD, s, w, '0);
                end
                else if (s == nmha_pkg::MAX_MEDOIDS - 1 && w == nmha_pkg::MAX_WORDS - 1)
                begin
                    send_word(nmha_pkg::REQ_LOAD, s, w, '1);
                end
                else
                begin
                    send_word(nmha_pkg::REQ_LOAD, s, w, rand64());
                end
            end
        end
    endtask

    // Reset settings: one medoid, one word of 64 sites.
    task automatic test_reset_defaults();
        send_query(0, '0);
        send_query(0, '1);
        send_query(1, rand64());
        send_query(nmha_pkg::MAX_WORDS - 1, rand64());
    endtask

    // Equal distances must resolve to the lower medoid number.
    task automatic test_ties();
        logic [nmha_pkg::WORD_W-1:0] pattern;
        pattern = rand64();
        configure(16, 64);
        send_word(nmha_pkg::REQ_LOAD, 9, 0, pattern);
        send_word(nmha_pkg::REQ_LOAD, 4, 0, pattern);
        send_word(nmha_pkg::REQ_LOAD, 12, 0, pattern ^ 64'd1);
        send_query(0, pattern);
        send_query(0, pattern ^ 64'd1);
        send_query(0, pattern ^ 64'd2);
    endtask

    // Site counts at the low end and beyond both ends, and a partial last word.
    task automatic test_site_counts();
        configure(16, 1);
        send_query(0, rand64());
        send_query(1, rand64());
        configure(16, 65);
        send_query(0, rand64());
        send_query(1, rand64());
        configure(16, 0);
        send_query(0, rand64());
        configure(16, 2047);
        for (int i = 0; i < nmha_pkg::MAX_WORDS; i++)
        begin
            send_query(i, (i % 2 == 0) ? '1 : '0);
        end
    endtask

    // Medoid counts of zero, one and beyond the maximum.
    task automatic test_medoid_counts();
        configure(0, 64);
        send_query(0, medoid_copy[15][0]);
        configure(31, 64);
        send_query(0, medoid_copy[15][0]);
        configure(17, 128);
        send_query(0, medoid_copy[11][0]);
        send_query(1, medoid_copy[11][1]);
        configure(1, 64);
        send_query(0, medoid_copy[11][0]);
    endtask

    // Words out of order, repeated, restarted and without a first word.
    task automatic test_word_order();
        configure(16, 256);
        send_query(0, near_word(3, 0));
        send_query(2, near_word(3, 2));
        send_query(1, near_word(3, 1));
        send_query(3, near_word(3, 3));
        send_query(3, near_word(6, 3));
        send_query(0, near_word(8, 0));
        send_query(1, near_word(8, 1));
        send_query(0, near_word(2, 0));
        send_query(3, near_word(2, 3));
        send_query(1, rand64());
        send_query(2, rand64());
        send_query(3, rand64());
    endtask

    // Repeating a word drives every sum into saturation.
    task automatic test_saturation();
        configure(16, 1024);
        for (int s = 0; s < nmha_pkg::MAX_MEDOIDS; s++)
        begin
            send_word(nmha_pkg::REQ_LOAD, s, 5, '0);
        end
        send_query(0, rand64());
        repeat (33) send_query(5, '1);
        send_query(nmha_pkg::MAX_WORDS - 1, rand64());
    endtask

    // Mostly whole haplotypes near a medoid, mixed with loads and stray words.
    task automatic test_random_haplotypes(input int n_items);
        int target;
        int start;
        int words;
        int pick;
        int k;
        int sites;
        target = items_sent + n_items;
        while (items_sent < target)
        begin
            pick = $urandom_range(19);
            k = (pick < 2) ? 0 : (pick < 4) ? 31 : (pick < 6) ? 17 : $urandom_range(1, 16);
            pick = $urandom_range(19);
            if (pick == 0)
            begin
                sites = ($urandom_range(1) == 0) ? 0 : 2047;
            end
            else if (pick == 1)
            begin
                sites = 1024;
            end
            else if (pick < 4)
            begin
                sites = $urandom_range(257, 1023);
            end
            else
            begin
                sites = $urandom_range(1, 256);
            end
            configure(k, sites);
            words = eff_word_count();
            start = items_sent;
            while (items_sent < target && items_sent - start < 60)
            begin
                pick = $urandom_range(99);
                if (pick < 65)
                begin
                    send_haplotype($urandom_range(nmha_pkg::MAX_MEDOIDS - 1), words);
                end
                else if (pick < 75)
                begin
                    send_word(nmha_pkg::REQ_LOAD, $urandom_range(nmha_pkg::MAX_MEDOIDS - 1),
                              $urandom_range(nmha_pkg::MAX_WORDS - 1), rand64());
                end
                else if (pick < 82)
                begin
                    // A haplotype cut short; the next one starts afresh.
                    for (int i = 0; i < $urandom_range(words); i++)
                    begin
                        send_query(i, near_word($urandom_range(nmha_pkg::MAX_MEDOIDS - 1), i));
                    end
                end
                else if (pick < 90)
                begin
                    send_query($urandom_range(words - 1), rand64());
                end
                else if (pick < 95)
                begin
                    if (words < nmha_pkg::MAX_WORDS)
                    begin
                        send_query($urandom_range(words, nmha_pkg::MAX_WORDS - 1), rand64());
                    end
                    else
                    begin
                        send_query($urandom_range(nmha_pkg::MAX_WORDS - 1), rand64());
                    end
                end
                else
                begin
                    drain_results(0);
                end
            end
        end
    endtask

    // Result checking, and the receiver's own stall pattern.
    always @(posedge clk)
    begin : check_results
        nearest_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_nearest.size() == 0)
            begin
                report_mismatch("result word with none expected", int'(best_medoid), -1);
            end
            else
            begin
                want = pending_nearest.pop_front();
                if (best_medoid !== want.medoid)
                begin
                    report_mismatch("best_medoid", int'(best_medoid), int'(want.medoid));
                end
                if (distance !== want.ham)
                begin
                    report_mismatch("distance", int'(distance), int'(want.ham));
                end
            end
        end
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(2);
            stall_left = $urandom_range(20, 200);
        end
        else
        begin
            stall_left--;
        end
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(3) == 0);
            default: out_stall <= ($urandom_range(9) < 7);
        endcase
    end

    // Guard against a hung block.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                     pending_nearest.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_store_fill();
        test_reset_defaults();
        test_ties();
        test_site_counts();
        test_medoid_counts();
        test_word_order();
        test_saturation();
        test_random_haplotypes(100);
        drain_results(SETTLE_CYCLES);
        if (mismatches == 0 && pending_nearest.size() == 0)
        begin
            $display("PASSED: all results match");
        end
        else
        begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

/* filelist.f */
design/nmha_pkg.sv
design/nmha_dp.sv
design/nmha_ctrl.sv
design/nearest_medoid_hamming_assign.sv
bench/testbench.sv
